### sv/gqqp_pkg.sv
// ----------------------------------------------------------------------------
// gqqp_pkg: shared types and constants for the Gaussian quantile packer
// Widths, threshold table, code width encodings and the queue item format.
// ----------------------------------------------------------------------------
package gqqp_pkg;

  localparam int WORD_WIDTH   = 32;
  localparam int SAMPLE_WIDTH = 16;
  localparam int CODE_W       = 4;   // widest code
  localparam int COUNT_W      = 5;   // codes held in the accumulator
  localparam int NUM_THR      = 15;

  // Positions of the 2-bit and 1-bit thresholds inside the 4-bit table
  localparam int THR_NEG_MID = 3;    // -0.6745
  localparam int THR_ZERO    = 7;    //  0
  localparam int THR_POS_MID = 11;   // +0.6745

  // Codes per word for each code width
  localparam logic [COUNT_W:0] LIMIT_1BIT = (COUNT_W+1)'(WORD_WIDTH / 1);
  localparam logic [COUNT_W:0] LIMIT_2BIT = (COUNT_W+1)'(WORD_WIDTH / 2);
  localparam logic [COUNT_W:0] LIMIT_4BIT = (COUNT_W+1)'(WORD_WIDTH / 4);

  // Queue between classifier and packer
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // Register encoding of code_width_mode (the unused code selects 4 bits)
  typedef enum logic [1:0] {
    MODE_1BIT = 2'd0,
    MODE_2BIT = 2'd1,
    MODE_4BIT = 2'd2
  } mode_t;

  // Code width carried with each classified sample
  typedef enum logic [1:0] {
    WIDTH_1 = 2'd0,
    WIDTH_2 = 2'd1,
    WIDTH_4 = 2'd2
  } width_t;

  typedef struct packed {
    width_t              width;
    logic [CODE_W-1:0]   code;
  } item_t;

  // Ascending Gaussian quantile thresholds, Q4.12, rounded to nearest
  localparam logic signed [SAMPLE_WIDTH-1:0] THR [NUM_THR] = '{
    -16'sd6284, -16'sd4712, -16'sd3634, -16'sd2763, -16'sd2002,
    -16'sd1305, -16'sd644,   16'sd0,     16'sd644,   16'sd1305,
     16'sd2002,  16'sd2763,  16'sd3634,  16'sd4712,  16'sd6284
  };

endpackage

### sv/gqqp_front.sv
// ----------------------------------------------------------------------------
// gqqp_front: sample classifier
// Holds the code width register, compares each accepted sample against the
// threshold table in parallel and pushes the code into the queue.
// ----------------------------------------------------------------------------
module gqqp_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [gqqp_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic                                 q_full,
  output logic                                 q_push,
  output gqqp_pkg::item_t                      q_item
);
  import gqqp_pkg::*;

  logic [1:0]         mode;
  logic [NUM_THR-1:0] ge;

  // Hold the code width register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_4BIT;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  // Compare against every threshold at once
  always_comb begin
    for (int i = 0; i < NUM_THR; i++) begin
      ge[i] = (sample >= THR[i]);
    end
  end

  // Form the code for the selected width
  always_comb begin
    unique case (mode)
      MODE_1BIT: begin
        q_item.width = WIDTH_1;
        q_item.code  = CODE_W'(ge[THR_ZERO]);
      end
      MODE_2BIT: begin
        q_item.width = WIDTH_2;
        q_item.code  = CODE_W'(ge[THR_NEG_MID]) + CODE_W'(ge[THR_ZERO])
                     + CODE_W'(ge[THR_POS_MID]);
      end
      default: begin
        q_item.width = WIDTH_4;
        q_item.code  = CODE_W'($countones(ge));
      end
    endcase
  end

  // Accept while the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

### sv/gqqp_queue.sv
// ----------------------------------------------------------------------------
// gqqp_queue: two-entry queue between classifier and packer
// Lets the classifier keep accepting while the packer waits on the output.
// ----------------------------------------------------------------------------
module gqqp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gqqp_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output gqqp_pkg::item_t pop_item
);
  import gqqp_pkg::*;

  item_t                  mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  // Write entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign full     = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign pop_item = mem[rd_ptr];

endmodule

### sv/gqqp_back.sv
// ----------------------------------------------------------------------------
// gqqp_back: code packer
// Shifts each code into the word accumulator and loads the output register
// once the word holds a full set of codes for the current width.
// ----------------------------------------------------------------------------
module gqqp_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  gqqp_pkg::item_t                    q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [gqqp_pkg::WORD_WIDTH-1:0]    packed_word
);
  import gqqp_pkg::*;

  logic [WORD_WIDTH-1:0] acc;
  logic [WORD_WIDTH-1:0] acc_next;
  logic [COUNT_W-1:0]    cnt;
  logic [COUNT_W:0]      cnt_inc;
  logic [COUNT_W:0]      limit;
  logic                  emit;

  // Shift in the code and pick the word limit
  always_comb begin
    unique case (q_item.width)
      WIDTH_1: begin
        acc_next = {acc[WORD_WIDTH-2:0], q_item.code[0]};
        limit    = LIMIT_1BIT;
      end
      WIDTH_2: begin
        acc_next = {acc[WORD_WIDTH-3:0], q_item.code[1:0]};
        limit    = LIMIT_2BIT;
      end
      default: begin
        acc_next = {acc[WORD_WIDTH-5:0], q_item.code};
        limit    = LIMIT_4BIT;
      end
    endcase
  end

  assign cnt_inc = {1'b0, cnt} + 1'b1;
  assign emit    = (cnt_inc >= limit);
  // Stall only when a finished word meets a full output register
  assign q_pop   = q_valid && (!emit || !out_valid || out_ready);

  // Advance the accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else if (q_pop) begin
      if (emit) begin
        acc <= '0;
        cnt <= '0;
      end else begin
        acc <= acc_next;
        cnt <= cnt_inc[COUNT_W-1:0];
      end
    end
  end

  // Hold the finished word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      packed_word <= acc_next;
    end
  end

endmodule

### sv/gaussian_quantile_quantize_pack_top.sv
// ----------------------------------------------------------------------------
// gaussian_quantile_quantize_pack_top: Gaussian quantile quantizer and packer
// Quantizes Q4.12 samples to 1, 2 or 4 bit codes and packs them into words.
//
//   Channel   Signals                         Direction  Moves
//   config    cfg_we, cfg_wdata               in         code width mode
//   sample    in_valid, in_ready, sample      in         one sample per request
//   word      out_valid, out_ready,           out        one packed word
//             packed_word
//
// One sample per cycle while the queue has room; a word leaves after 32, 16 or
// 8 samples for 1, 2 or 4 bit codes. The accepting edge of its last sample
// writes the queue; the output register loads when the packer pops that code.
// Reset sets the width to 4 bits and empties queue and accumulator.
// A stalled output register holds the packer; the two-entry queue lets the
// sample side keep going until it fills.
// ----------------------------------------------------------------------------
module gaussian_quantile_quantize_pack_top (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [1:0]                               cfg_wdata,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [gqqp_pkg::SAMPLE_WIDTH-1:0] sample,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [gqqp_pkg::WORD_WIDTH-1:0]          packed_word
);
  import gqqp_pkg::*;

  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_valid;
  item_t push_item;
  item_t pop_item;

  // Classify samples
  gqqp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  // Decouple classifier and packer
  gqqp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .pop_item  (pop_item)
  );

  // Pack codes into words
  gqqp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .packed_word (packed_word)
  );

  // Packer never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> !q_pop)
    else $error("packer popped an empty queue");

  // Queued codes stay until popped
  a_queue_keeps: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_pop |=> q_valid)
    else $error("queue lost an entry");

  // Classifier never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("push into full queue");

  // No word is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("word offered after reset");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Gaussian quantile quantizer and packer
// Streams Q4.12 samples through the block under every code width, including
// the unused mode and width changes with a half-filled word. A tracker
// classifies each accepted sample, packs the codes and holds the expected
// words; every word that leaves the block is compared with the oldest one.
// ----------------------------------------------------------------------------

class quant_word_tracker;

  localparam int FRAC_BITS = 12;

  logic [1:0]  width_mode;
  logic [31:0] acc;
  logic [5:0]  count;
  logic [31:0] expected_words[$];
  int          errors;

  function new();
    width_mode = gqqp_pkg::MODE_4BIT;
    acc        = '0;
    count      = '0;
    errors     = 0;
  endfunction

  // Ascending quantiles of the standard normal, in units of 1e-4
  static function int thr_e4(int idx);
    case (idx)
      0:       return -15341;
      1:       return -11503;
      2:       return -8871;
      3:       return -6745;
      4:       return -4888;
      5:       return -3186;
      6:       return -1573;
      7:       return 0;
      8:       return 1573;
      9:       return 3186;
      10:      return 4888;
      11:      return 6745;
      12:      return 8871;
      13:      return 11503;
      default: return 15341;
    endcase
  endfunction

  // Threshold in Q4.12, magnitude rounded half away from zero
  static function int thr_q(int idx);
    int v;
    int mag;
    int scaled;
    v      = thr_e4(idx);
    mag    = (v < 0) ? -v : v;
    scaled = ((mag << FRAC_BITS) + 5000) / 10000;
    return (v < 0) ? -scaled : scaled;
  endfunction

  // The unused mode falls back to 4 bits
  function int code_bits();
    if (width_mode == gqqp_pkg::MODE_1BIT) return 1;
    if (width_mode == gqqp_pkg::MODE_2BIT) return 2;
    return 4;
  endfunction

  // Narrow tables are the middle and quartile entries of the 4-bit one
  static function bit thr_used(int idx, int bits);
    if (bits == 4) return 1'b1;
    if (bits == 2) return (idx == 3) || (idx == 7) || (idx == 11);
    return idx == 7;
  endfunction

  // Classify one accepted sample and pack its code
  function void take_sample(logic signed [15:0] s);
    int bits;
    int code;
    bits = code_bits();
    code = 0;
    for (int i = 0; i < 15; i++) begin
      if (thr_used(i, bits) && (int'(s) >= thr_q(i))) code++;
    end
    acc   = (acc << bits) | 32'(code);
    count = count + 6'd1;
    if (count >= 6'(32 / bits)) begin
      expected_words.push_back(acc);
      acc   = '0;
      count = '0;
    end else begin
      count = count & 6'h1F;
    end
  endfunction

  // Compare one delivered word with the oldest expectation
  function void check_word(logic [31:0] word);
    logic [31:0] want;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual %08h", $time, word);
      errors++;
      return;
    end
    want = expected_words.pop_front();
    if (word !== want) begin
      $display("%0t: packed_word mismatch, expected %08h, actual %08h", $time, want, word);
      errors++;
    end
  endfunction

endclass

module tb;

  import gqqp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int SETTLE       = 4;    // classifier plus packer, with margin
  localparam int TAIL_CYCLES  = 8;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [1:0]                     cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] sample = '0;
  logic                           out_ready = 1'b0;
  logic                           in_ready;
  logic                           out_valid;
  logic [WORD_WIDTH-1:0]          packed_word;

  bit                             no_idle = 1'b0;
  int                             cycles = 0;
  quant_word_tracker              tracker;

  gaussian_quantile_quantize_pack_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .packed_word (packed_word)
  );

  always #5 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stall the word side at random
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 15);
  end

  // Check every word the block hands over
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_word(packed_word);
  end

  // Bias toward threshold edges and extremes, rest fully random
  function automatic logic signed [15:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      case ($urandom_range(3))
        0:       return 16'sh8000;
        1:       return 16'sh7FFF;
        2:       return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    if (r < 45) begin
      return 16'(tracker.thr_q($urandom_range(14)) + $urandom_range(2) - 1);
    end
    return 16'($urandom());
  endfunction

  // Offer one sample request, idling first at random
  task automatic send_sample(input logic signed [15:0] s);
    if (!no_idle) begin
      while ($urandom_range(99) < 15) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_sample(s);
  endtask

  // Hold the sample side until every expected word is out and the pipe is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.width_mode = m;
  endtask

  initial begin
    int sent;
    int phase;
    int len;
    logic [1:0] mode;

    tracker = new();
    sent    = 0;
    phase   = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset width is 4 bits: extremes and the outer threshold edges
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0000);
    send_sample(16'shFFFF);
    send_sample(16'(tracker.thr_q(14)));
    send_sample(16'(tracker.thr_q(14) - 1));
    send_sample(16'(tracker.thr_q(0)));
    send_sample(16'(tracker.thr_q(0) - 1));
    drain();

    // 2-bit word: each of its thresholds and just below
    write_mode(MODE_2BIT);
    send_sample(16'(tracker.thr_q(3)));
    send_sample(16'(tracker.thr_q(3) - 1));
    send_sample(16'(tracker.thr_q(7)));
    send_sample(16'(tracker.thr_q(7) - 1));
    send_sample(16'(tracker.thr_q(11)));
    send_sample(16'(tracker.thr_q(11) - 1));
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    for (int k = 0; k < 8; k++) send_sample(pick_sample());
    drain();

    // Random phases of uneven length, so width changes land mid-word
    while (sent < RANDOM_ITEMS) begin
      mode    = (phase < 4) ? 2'(phase) : 2'($urandom_range(3));
      len     = (phase == 5) ? 300 : $urandom_range(5, 120);
      no_idle = (phase == 5);
      write_mode(mode);
      for (int k = 0; k < len; k++) begin
        send_sample(pick_sample());
        sent++;
      end
      drain();
      phase++;
    end

    // Finish on the unused mode and the 1-bit setting
    write_mode(MODE_UNUSED);
    for (int k = 0; k < 12; k++) send_sample(pick_sample());
    drain();
    write_mode(MODE_1BIT);
    for (int k = 0; k < 40; k++) send_sample(pick_sample());
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (tracker.errors == 0 && tracker.expected_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
